FILE: rtl/core/snpf_pkg.sv
// Shared types, constants and helper functions for the sequence number path formatter.
// No dependencies; all other files in rtl/core import this package.
package snpf_pkg;

	// Range and conversion geometry
	localparam logic [31:0] SEQ_MAX      = 32'd999999999;
	localparam int          DIGITS       = 9;
	localparam int          BCD_W        = 4 * DIGITS;
	localparam int          BIN_W        = 30;
	localparam int          BITS_PER_CYC = 3;
	localparam int          CONV_CYCLES  = BIN_W / BITS_PER_CYC;
	localparam int          CNT_W        = $clog2(CONV_CYCLES + 1);

	// Character stream geometry
	localparam int          CHARS        = 11;
	localparam int          POS_W        = $clog2(CHARS);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(CHARS - 1);

	// Character codes
	localparam logic [6:0]  CHAR_ZERO    = 7'h30;
	localparam logic [6:0]  CHAR_SLASH   = 7'h2F;
	localparam logic [6:0]  CHAR_NONE    = 7'h00;

	// One converted item passed from front to back
	typedef struct packed {
		logic             err;
		logic [BCD_W-1:0] bcd;
	} snpf_entry_t;

	// One double-dabble step: correct each digit, then shift in one binary bit
	function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] bcd_in,
		input logic bit_in);
		logic [BCD_W-1:0] adj;
		adj = bcd_in;
		for (int j = 0; j < DIGITS; j++) begin
			if (adj[4*j +: 4] >= 4'd5) begin
				adj[4*j +: 4] = adj[4*j +: 4] + 4'd3;
			end
		end
		return {adj[BCD_W-2:0], bit_in};
	endfunction

endpackage

FILE: rtl/core/snpf_front.sv
// Front end: accepts sequence numbers, checks range, converts to BCD by double dabble.
// Depends on snpf_pkg; pushes finished entries into snpf_queue.
module snpf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic signed [31:0]   sequence_number,
	output logic                 q_push,
	output snpf_pkg::snpf_entry_t q_data,
	input  logic                 q_full
);
	import snpf_pkg::*;

	logic                 busy_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 err_q;
	logic [BIN_W-1:0]     bin_q;
	logic [BCD_W-1:0]     bcd_q;
	logic                 in_fire;
	logic                 in_err;
	logic [BCD_W-1:0]     bcd_next;

	// Hand off the finished entry, and take a new beat in the same cycle
	assign q_push  = busy_q && (cnt_q == '0) && !q_full;
	assign full    = busy_q && !q_push;
	assign in_fire = push && !full;
	assign in_err  = sequence_number[31] || ($unsigned(sequence_number) > SEQ_MAX);
	assign q_data  = '{err: err_q, bcd: bcd_q};

	// Run three double-dabble steps per cycle
	always_comb begin
		bcd_next = bcd_q;
		for (int k = 0; k < BITS_PER_CYC; k++) begin
			bcd_next = dd_step(bcd_next, bin_q[BIN_W-1-k]);
		end
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (in_fire) begin
				busy_q <= 1'b1;
				cnt_q  <= in_err ? '0 : CNT_W'(CONV_CYCLES);
			end else begin
				if (q_push) begin
					busy_q <= 1'b0;
				end
				if (busy_q && (cnt_q != '0)) begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	// Load and advance the conversion registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			err_q <= in_err;
			bin_q <= sequence_number[BIN_W-1:0];
			bcd_q <= '0;
		end else if (busy_q && (cnt_q != '0)) begin
			bin_q <= bin_q << BITS_PER_CYC;
			bcd_q <= bcd_next;
		end
	end

	// Idle front never counts, and a counting front never hands off
	a_idle_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (cnt_q == '0)) else $error("front counter running while idle");
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> !q_push) else $error("front handed off before conversion done");
	a_busy_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && (cnt_q != '0)) |=> busy_q) else $error("front dropped a conversion");

endmodule

FILE: rtl/core/snpf_queue.sv
// Two-entry queue between front and back end.
// Depends on snpf_pkg for the entry type.
module snpf_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_en,
	input  snpf_pkg::snpf_entry_t wr_data,
	output logic                 q_full,
	input  logic                 rd_en,
	output snpf_pkg::snpf_entry_t rd_data,
	output logic                 q_empty
);
	import snpf_pkg::*;

	snpf_entry_t mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;

	assign q_full  = (cnt_q == 2'd2);
	assign q_empty = (cnt_q == 2'd0);
	assign rd_data = mem_q[rd_ptr_q];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// Store written entries
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !q_full) else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !q_empty) else $error("queue read while empty");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count out of range");

endmodule

FILE: rtl/core/snpf_back.sv
// Back end: walks the queue head and emits one ASCII character per beat.
// Depends on snpf_pkg; reads entries from snpf_queue.
module snpf_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  snpf_pkg::snpf_entry_t head,
	input  logic                 q_empty,
	output logic                 q_pop,
	output logic                 empty,
	input  logic                 pop,
	output logic [6:0]           out_char,
	output logic                 last_char,
	output logic                 range_error
);
	import snpf_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] digit_idx;
	logic [3:0]       digit;
	logic             out_fire;

	assign empty       = q_empty;
	assign out_fire    = pop && !q_empty;
	assign range_error = head.err;
	assign last_char   = head.err || (pos_q == LAST_POS);
	assign q_pop       = out_fire && last_char;

	// Pick the digit for this position: one slash between groups of three digits
	assign digit_idx = pos_q - POS_W'(pos_q[POS_W-1:2]);
	assign digit     = head.bcd[(DIGITS - 1 - int'(digit_idx)) * 4 +: 4];

	always_comb begin
		if (head.err) begin
			out_char = CHAR_NONE;
		end else if (pos_q[1:0] == 2'b11) begin
			out_char = CHAR_SLASH;
		end else begin
			out_char = CHAR_ZERO + {3'b000, digit};
		end
	end

	// Advance the character position, wrap on the last beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (out_fire) begin
			pos_q <= last_char ? '0 : pos_q + 1'b1;
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LAST_POS) else $error("character position out of range");
	a_pos_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q != '0) |-> (!q_empty && !head.err)) else $error("position without entry");
	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!out_fire |=> $stable(pos_q)) else $error("position moved without a beat");

endmodule

FILE: rtl/core/sequence_number_path_formatter.sv
// Top level of the sequence number path formatter.
// Depends on snpf_pkg, snpf_front, snpf_queue and snpf_back.
//
// Input channel: push/full carrying a signed 32-bit sequence_number. A number
// in 0..999999999 becomes eleven result beats DDD/DDD/DDD (out_char in ASCII,
// most significant digit first), last_char set on the eleventh. A negative or
// too large number becomes one beat with out_char zero, last_char and
// range_error set.
// Result channel: empty/pop; the oldest beat is on the ports while empty is low.
// A valid number is converted by double dabble, three bits at a time, and the
// finished entry is then written to the queue; an out-of-range number skips the
// conversion. The converter takes no new number until it hands off the current
// one, and the result port gives one character per beat.
// A two-entry queue separates converter and emitter, so conversion of the next
// number goes on while the receiver stalls. full is high while a conversion
// runs and while a converted entry waits for a free queue slot.
// Reset clears all control state; the block comes up empty and not full.
module sequence_number_path_formatter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] sequence_number,
	output logic               empty,
	input  logic               pop,
	output logic [6:0]         out_char,
	output logic               last_char,
	output logic               range_error
);
	import snpf_pkg::*;

	snpf_entry_t wr_data;
	snpf_entry_t head;
	logic        wr_en;
	logic        q_full;
	logic        q_empty;
	logic        q_pop;

	// Convert
	snpf_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.sequence_number (sequence_number),
		.q_push          (wr_en),
		.q_data          (wr_data),
		.q_full          (q_full)
	);

	// Buffer
	snpf_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.q_full  (q_full),
		.rd_en   (q_pop),
		.rd_data (head),
		.q_empty (q_empty)
	);

	// Emit
	snpf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_empty     (q_empty),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.out_char    (out_char),
		.last_char   (last_char),
		.range_error (range_error)
	);

endmodule

FILE: dv/tb_sequence_number_path_formatter.sv
// Self-checking testbench for sequence_number_path_formatter: directed and random numbers,
// each predicted as DDD/DDD/DDD characters or one range error beat and checked in order.
// Depends on snpf_pkg and the sequence_number_path_formatter RTL.
`timescale 1ns / 100ps

import snpf_pkg::*;

typedef struct packed {
	logic [6:0] ch;
	logic       last;
	logic       err;
} path_char_t;

// Predicts the character stream of each accepted number and checks every popped beat
class path_char_checker;
	path_char_t expected_chars[$];
	int unsigned mismatches;
	int unsigned numbers_in;
	int unsigned range_errors_in;
	int unsigned chars_checked;

	function new();
		mismatches = 0;
		numbers_in = 0;
		range_errors_in = 0;
		chars_checked = 0;
	endfunction

	task report(input string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		mismatches++;
	endtask

	// Expand one accepted number into its expected beats
	function void note_number(input logic signed [31:0] n);
		path_char_t  b;
		int unsigned rest;
		int unsigned dig[DIGITS];
		numbers_in++;
		if (n[31] || $unsigned(n) > SEQ_MAX) begin
			range_errors_in++;
			b.ch = CHAR_NONE;
			b.last = 1'b1;
			b.err = 1'b1;
			expected_chars.push_back(b);
			return;
		end
		rest = $unsigned(n);
		for (int i = DIGITS - 1; i >= 0; i--) begin
			dig[i] = rest % 10;
			rest = rest / 10;
		end
		for (int i = 0; i < DIGITS; i++) begin
			// slash between groups of three
			if (i > 0 && (i % 3) == 0) begin
				b.ch = CHAR_SLASH;
				b.last = 1'b0;
				b.err = 1'b0;
				expected_chars.push_back(b);
			end
			b.ch = CHAR_ZERO + 7'(dig[i]);
			b.last = (i == DIGITS - 1);
			b.err = 1'b0;
			expected_chars.push_back(b);
		end
	endfunction

	// Compare one popped beat against the oldest expectation
	task check_char(input logic [6:0] ch, input logic last, input logic err);
		path_char_t e;
		chars_checked++;
		if (expected_chars.size() == 0) begin
			report($sformatf("beat char=%h last=%b err=%b with nothing expected", ch, last, err));
			return;
		end
		e = expected_chars.pop_front();
		if (ch !== e.ch)
			report($sformatf("out_char got %h want %h", ch, e.ch));
		if (last !== e.last)
			report($sformatf("last_char got %b want %b (char %h)", last, e.last, e.ch));
		if (err !== e.err)
			report($sformatf("range_error got %b want %b (char %h)", err, e.err, e.ch));
	endtask

	function int pending();
		return expected_chars.size();
	endfunction

	task check_drained();
		if (expected_chars.size() != 0)
			report($sformatf("%0d beats never arrived", expected_chars.size()));
	endtask
endclass

module tb_sequence_number_path_formatter;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int          RANDOM_ITEMS = 310;
	localparam int          HOLD_CYCLES  = 400;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic signed [31:0] sequence_number = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic [6:0]         out_char;
	logic               last_char;
	logic               range_error;

	path_char_checker   chk = new();
	int unsigned        cycles = 0;
	int unsigned        beats_popped = 0;
	int unsigned        holds_done = 0;

	sequence_number_path_formatter u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.full            (full),
		.sequence_number (sequence_number),
		.empty           (empty),
		.pop             (pop),
		.out_char        (out_char),
		.last_char       (last_char),
		.range_error     (range_error)
	);

	always #5 clk = ~clk;

	// Watchdog on total run length
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d beats outstanding", cycles, chk.pending());
			$display("Regression FAIL");
			$finish;
		end
	end

	// Offer one number and hold it until the block takes it
	task send_number(input logic signed [31:0] n);
		push <= 1'b1;
		sequence_number <= n;
		do @(posedge clk); while (full);
		chk.note_number(n);
	endtask

	// Drop push for a gap of the given length
	task pause_sender(input int n);
		if (n > 0) begin
			push <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Mix of in-range, small, negative, above-maximum and near-boundary numbers
	function automatic logic signed [31:0] pick_number();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1, 2, 3, 4, 5: return $urandom_range(0, SEQ_MAX);
			6:                return $urandom_range(0, 999);
			7:                return {1'b1, 31'($urandom)};
			8:                return $urandom_range(32'd1000000000, 32'h7FFFFFFF);
			default:          return ($urandom_range(0, 1) == 1) ?
				SEQ_MAX - $urandom_range(0, 3) : SEQ_MAX + 1 + $urandom_range(0, 3);
		endcase
	endfunction

	// Receiver: check each popped beat, stall on a shifting pattern, hold off twice
	always @(posedge clk) begin
		int unsigned hold_left;
		int unsigned phase;
		if (arst_n) begin
			if (pop && !empty) begin
				chk.check_char(out_char, last_char, range_error);
				beats_popped <= beats_popped + 1;
			end
			if (hold_left == 0 && holds_done < 2 &&
				beats_popped >= (holds_done == 0 ? 400 : 1800)) begin
				hold_left = HOLD_CYCLES;
				holds_done <= holds_done + 1;
			end
			phase = (cycles / 64) % 4;
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				case (phase)
					0:       pop <= 1'b1;
					1:       pop <= ($urandom_range(0, 1) == 1);
					2:       pop <= ($urandom_range(0, 9) == 0);
					default: pop <= cycles[1];
				endcase
			end
		end else begin
			hold_left = 0;
		end
	end

	initial begin
		logic signed [31:0] directed_numbers[$];
		int                 sent;
		int                 burst;
		directed_numbers = '{32'sd0, 32'sd1, 32'sd9, 32'sd10, 32'sd999, 32'sd1000,
			32'sd123456789, 32'sd987654321, 32'sd99999999, 32'sd100000000,
			32'sd500000000, 32'sd999999998, 32'sd999999999, 32'sd1000000000,
			32'sd1073741823, 32'sd2147483647, -32'sd1, -32'sd2147483648,
			32'sd555555555, 32'sd0};

		// Hold reset, then release it
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, boundaries, both error kinds, back-to-back
		foreach (directed_numbers[i])
			send_number(directed_numbers[i]);
		pause_sender(3);

		// Random bursts with random gaps, some stretches with no gaps at all
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			burst = $urandom_range(1, 12);
			for (int j = 0; j < burst && sent < RANDOM_ITEMS; j++) begin
				send_number(pick_number());
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				pause_sender($urandom_range(1, 20));
		end
		push <= 1'b0;

		// Drain, then allow any stray beats to show
		while (chk.pending() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		chk.check_drained();

		$display("Covered %0d numbers (%0d out of range), %0d beats checked, %0d long hold-offs",
			chk.numbers_in, chk.range_errors_in, chk.chars_checked, holds_done);
		if (chk.mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", chk.mismatches);
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

FILE: sequence_number_path_formatter.f
rtl/core/snpf_pkg.sv
rtl/core/snpf_front.sv
rtl/core/snpf_queue.sv
rtl/core/snpf_back.sv
rtl/core/sequence_number_path_formatter.sv
dv/tb_sequence_number_path_formatter.sv
